>>> sv/lfu_pkg.sv
// Shared types and constants of the LFU set-associative tag store.
package lfu_pkg;

  // Default geometry
  localparam int SET_BITS_DEF   = 6;
  localparam int WAYS_DEF       = 4;
  localparam int BLOCK_BITS_DEF = 4;
  localparam int TAG_BITS_DEF   = 22;

  // Fixed port and counter widths
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int WAY_OUT_W = 2;
  localparam int TAG_OUT_W = 22;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_addr;  // capture the accepted address
    logic read;       // read the set row from the tag and count arrays
    logic update;     // write back the set row and load the result registers
  } cmd_t;

endpackage

>>> sv/lfu_ctrl.sv
// Controller state machine of the LFU tag store: sequences read, update and result transfer.
module lfu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lfu_pkg::cmd_t cmd
);

  lfu_pkg::state_t state, state_next;
  logic            out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lfu_pkg::ST_IDLE: begin
        if (in_valid) state_next = lfu_pkg::ST_READ;
      end
      lfu_pkg::ST_READ: begin
        state_next = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        if (out_free) state_next = lfu_pkg::ST_IDLE;
      end
      default: state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.load_addr = 1'b0;
    cmd.read      = 1'b0;
    cmd.update    = 1'b0;
    case (state)
      lfu_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_addr = in_valid;
      end
      lfu_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      lfu_pkg::ST_UPDATE: begin
        cmd.update = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // state and result-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfu_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> sv/lfu_dpath.sv
// Datapath of the LFU tag store: set arrays, valid bits, tag compare, victim choice, result regs.
module lfu_dpath #(
  parameter int SET_BITS   = lfu_pkg::SET_BITS_DEF,
  parameter int WAYS       = lfu_pkg::WAYS_DEF,
  parameter int BLOCK_BITS = lfu_pkg::BLOCK_BITS_DEF,
  parameter int TAG_BITS   = lfu_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lfu_pkg::cmd_t                   cmd,
  input  logic [lfu_pkg::ADDR_W-1:0]      access_address,
  output logic                            hit,
  output logic [lfu_pkg::WAY_OUT_W-1:0]   way,
  output logic                            replaced_valid,
  output logic [lfu_pkg::TAG_OUT_W-1:0]   replaced_tag
);

  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = lfu_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // captured access
  logic [SET_W-1:0]    set_q;
  logic [TAG_BITS-1:0] tag_q;

  // set rows: tags and use counts in memory, valid bits in flops
  logic [WAYS*TAG_BITS-1:0] tag_mem [NUM_SETS];
  logic [WAYS*CNT_W-1:0]    cnt_mem [NUM_SETS];
  logic [WAYS-1:0]          valid   [NUM_SETS];

  logic [WAYS*TAG_BITS-1:0] rd_tag_row;
  logic [WAYS*CNT_W-1:0]    rd_cnt_row;
  logic [WAYS*TAG_BITS-1:0] tag_row_next;
  logic [WAYS*CNT_W-1:0]    cnt_row_next;
  logic [WAYS-1:0]          valid_row;
  logic [WAYS-1:0]          valid_row_next;

  // lookup results
  logic                found;
  logic                have_invalid;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    invalid_way;
  logic [WAY_W-1:0]    lfu_way;
  logic [WAY_W-1:0]    victim;
  logic [TAG_BITS-1:0] old_tag;
  logic [CNT_W-1:0]    hit_cnt;
  logic [31:0]         way_wide;
  logic [31:0]         tag_wide;

  // address capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      if (SET_BITS > 0) set_q <= SET_W'(access_address >> BLOCK_BITS);
      else set_q <= '0;
      tag_q <= TAG_BITS'(access_address >> (SET_BITS + BLOCK_BITS));
    end
  end

  // set row memories: registered read, row write-back
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      tag_mem[set_q] <= tag_row_next;
      cnt_mem[set_q] <= cnt_row_next;
    end
    if (cmd.read) begin
      rd_tag_row <= tag_mem[set_q];
      rd_cnt_row <= cnt_mem[set_q];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) valid[s] <= '0;
    end else if (cmd.update) begin
      valid[set_q] <= valid_row_next;
    end
  end

  assign valid_row = valid[set_q];

  // hit search and first invalid way, lowest index wins
  always_comb begin
    found        = 1'b0;
    have_invalid = 1'b0;
    hit_way      = '0;
    invalid_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_row[w]) begin
        if (!found && rd_tag_row[w*TAG_BITS +: TAG_BITS] == tag_q) begin
          found   = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else if (!have_invalid) begin
        have_invalid = 1'b1;
        invalid_way  = WAY_W'(w);
      end
    end
  end

  // least-used way, lowest index on ties
  always_comb begin
    lfu_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (rd_cnt_row[w*CNT_W +: CNT_W] < rd_cnt_row[32'(lfu_way)*CNT_W +: CNT_W])
        lfu_way = WAY_W'(w);
    end
  end

  assign victim  = have_invalid ? invalid_way : lfu_way;
  assign old_tag = rd_tag_row[32'(victim)*TAG_BITS +: TAG_BITS];
  assign hit_cnt = rd_cnt_row[32'(hit_way)*CNT_W +: CNT_W];

  // row write-back: saturating bump on hit, fresh line on miss
  always_comb begin
    tag_row_next   = rd_tag_row;
    cnt_row_next   = rd_cnt_row;
    valid_row_next = valid_row;
    if (found) begin
      if (hit_cnt != CNT_MAX)
        cnt_row_next[32'(hit_way)*CNT_W +: CNT_W] = hit_cnt + CNT_W'(1);
    end else begin
      tag_row_next[32'(victim)*TAG_BITS +: TAG_BITS] = tag_q;
      cnt_row_next[32'(victim)*CNT_W +: CNT_W]       = CNT_W'(1);
      valid_row_next[victim]                         = 1'b1;
    end
  end

  assign way_wide = found ? 32'(hit_way) : 32'(victim);
  assign tag_wide = 32'(old_tag);

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit            <= found;
      way            <= way_wide[lfu_pkg::WAY_OUT_W-1:0];
      replaced_valid <= !found && !have_invalid;
      replaced_tag   <= (!found && !have_invalid) ? tag_wide[lfu_pkg::TAG_OUT_W-1:0] : '0;
    end
  end

endmodule

>>> sv/lfu_set_assoc_tag_store_core.sv
// Top level of the LFU set-associative tag store: controller plus datapath.
// Sequence: the address is captured on the input transfer, the set row is read, then the update loads the result.
// A new access is taken only in idle, after the previous access has read and written back its set row.
// A new access is taken while the previous result still waits in the result register.
// Reset (rst, synchronous) clears all valid bits at once and empties the result register.
module lfu_set_assoc_tag_store_core #(
  parameter int SET_BITS   = lfu_pkg::SET_BITS_DEF,
  parameter int WAYS       = lfu_pkg::WAYS_DEF,
  parameter int BLOCK_BITS = lfu_pkg::BLOCK_BITS_DEF,
  parameter int TAG_BITS   = lfu_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lfu_pkg::ADDR_W-1:0]    access_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [lfu_pkg::WAY_OUT_W-1:0] way,
  output logic                          replaced_valid,
  output logic [lfu_pkg::TAG_OUT_W-1:0] replaced_tag
);

  lfu_pkg::cmd_t cmd;

  // sequencing
  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // storage and lookup
  lfu_dpath #(
    .SET_BITS   (SET_BITS),
    .WAYS       (WAYS),
    .BLOCK_BITS (BLOCK_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .access_address (access_address),
    .hit            (hit),
    .way            (way),
    .replaced_valid (replaced_valid),
    .replaced_tag   (replaced_tag)
  );

endmodule

>>> sv/lfu_checker.sv
// Port-level assertions for the LFU tag store top level, with their bind.
module lfu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [lfu_pkg::ADDR_W-1:0]    access_address,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic [lfu_pkg::WAY_OUT_W-1:0] way,
  input logic                          replaced_valid,
  input logic [lfu_pkg::TAG_OUT_W-1:0] replaced_tag
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way)
      && $stable(replaced_valid) && $stable(replaced_tag))
    else $error("result changed while stalled");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !replaced_valid)
    else $error("hit reported an eviction");

  // no eviction means a zero replaced tag
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !replaced_valid |-> replaced_tag == '0)
    else $error("replaced tag nonzero without eviction");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // one access at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

endmodule

bind lfu_set_assoc_tag_store_core lfu_checker u_lfu_checker (.*);
